### rtl/mexp_pkg.sv
// Shared types for the modular exponentiation controller and datapath.
package mexp_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_BIT,
    ST_MUL_ACC,
    ST_NEXT,
    ST_MUL_SQ,
    ST_FINISH
  } state_t;

  // Selects which register feeds the multiplicand of the modular multiplier.
  typedef enum logic {
    MSEL_ACC,
    MSEL_SQ
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     red_step;
    logic     mul_start;
    logic     mul_step;
    logic     mul_write;
    mul_sel_t mul_sel;
    logic     e_shift;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_lsb;
    logic e_rest_zero;
    logic red_last;
    logic mul_idle;
  } status_t;

endpackage

### rtl/mexp_datapath.sv
// Datapath: operand registers, base reduction and bit-serial modular multiplier.
module mexp_datapath #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  mexp_pkg::cmd_t       cmd,
  output mexp_pkg::status_t    status,
  input  logic [63:0]          base_value,
  input  logic [63:0]          exponent_value,
  input  logic [63:0]          modulus_value,
  output logic [63:0]          power_result,
  output logic                 zero_modulus_error
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  m;
  logic [W-1:0]  e;
  logic [W-1:0]  acc;
  logic [W-1:0]  sq;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [W-1:0]  mp;
  logic [CW-1:0] cnt;

  logic [W-1:0]  b_in;
  logic [W-1:0]  e_in;
  logic [W-1:0]  m_in;
  logic [W-1:0]  acc_init;
  logic [W-1:0]  red_next;
  logic [W-1:0]  mp_next;
  logic [W-1:0]  ma_next;

  // Sum of two residues below m, reduced by one conditional subtraction.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, md}) begin
      s = s - {1'b0, md};
    end
    return s[W-1:0];
  endfunction

  // Inputs are taken at the operand width; bits above it are ignored.
  assign b_in = base_value[W-1:0];
  assign e_in = exponent_value[W-1:0];
  assign m_in = modulus_value[W-1:0];

  // A modulus of one makes every nonzero power zero; a zero exponent gives one.
  assign acc_init = ((m_in == W'(1)) && (e_in != '0)) ? '0 : W'(1);

  // One remainder step of the base reduction: r = (2r + next base bit) mod m.
  always_comb begin
    logic [W:0] r;
    r = {sq, mb[W-1]};
    if (r >= {1'b0, m}) begin
      r = r - {1'b0, m};
    end
    red_next = r[W-1:0];
  end

  // One multiplier step: add the multiplicand on a set bit, double it every step.
  assign mp_next = mb[0] ? add_mod(mp, ma, m) : mp;
  assign ma_next = add_mod(ma, ma, m);

  // Operand and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m   <= m_in;
      e   <= e_in;
      acc <= acc_init;
      sq  <= '0;
      mb  <= b_in;
      cnt <= CW'(W - 1);
    end else begin
      if (cmd.red_step) begin
        sq  <= red_next;
        mb  <= {mb[W-2:0], 1'b0};
        cnt <= cnt - CW'(1);
      end
      if (cmd.mul_start) begin
        ma <= (cmd.mul_sel == mexp_pkg::MSEL_ACC) ? acc : sq;
        mb <= sq;
        mp <= '0;
      end
      if (cmd.mul_step) begin
        mp <= mp_next;
        ma <= ma_next;
        mb <= {1'b0, mb[W-1:1]};
      end
      if (cmd.mul_write) begin
        if (cmd.mul_sel == mexp_pkg::MSEL_ACC) begin
          acc <= mp;
        end else begin
          sq <= mp;
        end
      end
      if (cmd.e_shift) begin
        e <= {1'b0, e[W-1:1]};
      end
    end
  end

  // Result register, held until the transaction is taken.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      power_result       <= (m == '0) ? 64'd0 : 64'(acc);
      zero_modulus_error <= (m == '0);
    end
  end

  // Status back to the controller.
  always_comb begin
    status.m_zero      = (m == '0);
    status.e_zero      = (e == '0);
    status.e_lsb       = e[0];
    status.e_rest_zero = (e[W-1:1] == '0);
    status.red_last    = (cnt == '0);
    status.mul_idle    = (mb == '0);
  end

endmodule

### rtl/mexp_control.sv
// Controller: sequences base reduction, square-and-multiply steps and output.
module mexp_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd
);

  mexp_pkg::state_t state;
  mexp_pkg::state_t state_next;
  logic             out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mexp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_sel   = mexp_pkg::MSEL_ACC;
    in_ready      = 1'b0;
    case (state)
      mexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (status.m_zero || status.e_zero) begin
          state_next = mexp_pkg::ST_FINISH;
        end else begin
          state_next = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        cmd.red_step = 1'b1;
        if (status.red_last) begin
          state_next = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_BIT: begin
        if (status.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mexp_pkg::MSEL_ACC;
          state_next    = mexp_pkg::ST_MUL_ACC;
        end else begin
          state_next = mexp_pkg::ST_NEXT;
        end
      end
      mexp_pkg::ST_MUL_ACC: begin
        cmd.mul_sel = mexp_pkg::MSEL_ACC;
        if (status.mul_idle) begin
          cmd.mul_write = 1'b1;
          state_next    = mexp_pkg::ST_NEXT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      mexp_pkg::ST_NEXT: begin
        // The square after the top exponent bit is never used.
        if (status.e_rest_zero) begin
          state_next = mexp_pkg::ST_FINISH;
        end else begin
          cmd.e_shift   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mexp_pkg::MSEL_SQ;
          state_next    = mexp_pkg::ST_MUL_SQ;
        end
      end
      mexp_pkg::ST_MUL_SQ: begin
        cmd.mul_sel = mexp_pkg::MSEL_SQ;
        if (status.mul_idle) begin
          cmd.mul_write = 1'b1;
          state_next    = mexp_pkg::ST_BIT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  // The output transaction stays valid until taken.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

endmodule

### rtl/modular_exponentiation.sv
// Sequence: for a zero modulus or a zero exponent, an input transaction goes from the check
// straight to the output load; otherwise check, base reduction and output load, plus per
// exponent bit the ST_BIT and ST_NEXT control states and up to two multiplies.
// Throughput: one transaction at a time, as in_ready is high only in the idle state, with
// the single shift-and-add multiplier doing every multiply. Reset clears control and valid.
// Top level: modular exponentiation by right-to-left square-and-multiply.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] base_value,
  input  logic [63:0] exponent_value,
  input  logic [63:0] modulus_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] power_result,
  output logic        zero_modulus_error
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  // Sequencing of the square-and-multiply loop.
  mexp_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Operand registers and modular arithmetic.
  mexp_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .status             (status),
    .base_value         (base_value),
    .exponent_value     (exponent_value),
    .modulus_value      (modulus_value),
    .power_result       (power_result),
    .zero_modulus_error (zero_modulus_error)
  );

endmodule
